// ----- hdl/bsot_pkg.sv -----
// Shared types and widths for the box and sphere overlap test.
package bsot_pkg;

    // Doubled coordinates and gaps, signed
    localparam int D_W   = 35;
    // Gap or doubled radius magnitude
    localparam int MAG_W = 34;
    // Square of a magnitude
    localparam int SQ_W  = 2 * MAG_W;
    // Sum of three squares
    localparam int SUM_W = SQ_W + 2;

    localparam int POS_W  = 32;
    localparam int SIZE_W = 31;
    localparam int AXES   = 3;

    typedef enum logic [1:0] {
        OP_LOAD_BOX    = 2'd0,
        OP_LOAD_SPHERE = 2'd1,
        OP_TEST_BOX    = 2'd2,
        OP_TEST_SPHERE = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        MODE_NO_FIRST = 2'd0,
        MODE_BOX_BOX  = 2'd1,
        MODE_SQUARED  = 2'd2
    } t_mode;

    // Control carried alongside the distance terms
    typedef struct packed {
        logic  valid;
        t_mode mode;
        logic  box_hit;
    } t_ctl;

endpackage

// ----- hdl/bsot_axis.sv -----
// One axis: interval overlap and sphere-centre-to-box gap in doubled units.
module bsot_axis (
    input  logic signed [bsot_pkg::POS_W-1:0]  i_box_c,
    input  logic        [bsot_pkg::SIZE_W-1:0] i_box_s,
    input  logic signed [bsot_pkg::POS_W-1:0]  i_oth_c,
    input  logic        [bsot_pkg::SIZE_W-1:0] i_oth_s,
    output logic                               o_overlap,
    output logic        [bsot_pkg::MAG_W-1:0]  o_dist
);

    logic signed [bsot_pkg::D_W-1:0] box_c2;
    logic signed [bsot_pkg::D_W-1:0] box_sx;
    logic signed [bsot_pkg::D_W-1:0] oth_c2;
    logic signed [bsot_pkg::D_W-1:0] oth_sx;
    logic signed [bsot_pkg::D_W-1:0] box_lo;
    logic signed [bsot_pkg::D_W-1:0] box_hi;
    logic signed [bsot_pkg::D_W-1:0] oth_lo;
    logic signed [bsot_pkg::D_W-1:0] oth_hi;
    logic signed [bsot_pkg::D_W-1:0] lo_gap;
    logic signed [bsot_pkg::D_W-1:0] hi_gap;

    assign box_c2 = bsot_pkg::D_W'(i_box_c) <<< 1;
    assign oth_c2 = bsot_pkg::D_W'(i_oth_c) <<< 1;
    assign box_sx = bsot_pkg::D_W'(i_box_s);
    assign oth_sx = bsot_pkg::D_W'(i_oth_s);

    assign box_lo = box_c2 - box_sx;
    assign box_hi = box_c2 + box_sx;
    assign oth_lo = oth_c2 - oth_sx;
    assign oth_hi = oth_c2 + oth_sx;

    assign o_overlap = (box_lo <= oth_hi) && (box_hi >= oth_lo);

    // Clamp the other centre to the box: at most one side can have a positive gap
    assign lo_gap = box_lo - oth_c2;
    assign hi_gap = oth_c2 - box_hi;

    always_comb begin
        if (lo_gap > 0) begin
            o_dist = lo_gap[bsot_pkg::MAG_W-1:0];
        end else if (hi_gap > 0) begin
            o_dist = hi_gap[bsot_pkg::MAG_W-1:0];
        end else begin
            o_dist = '0;
        end
    end

endmodule

// ----- hdl/bsot_sq.sv -----
// Registered square of one magnitude.
module bsot_sq (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [bsot_pkg::MAG_W-1:0]    i_val,
    output logic [bsot_pkg::SQ_W-1:0]     o_sq
);

    logic [bsot_pkg::SQ_W-1:0] r_sq;
    logic [bsot_pkg::SQ_W-1:0] n_sq;

    assign n_sq = bsot_pkg::SQ_W'(i_val) * bsot_pkg::SQ_W'(i_val);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

// ----- hdl/box_sphere_overlap_test.sv -----
// Top level: collider store, four-stage pipeline and handshakes.
//
//   channel   direction  handshake          payload
//   input     in         i_valid / o_stall  i_opcode, i_pos_*, i_size_*
//   result    out        o_valid / i_stall  o_collide, o_status
//
// One word accepted per cycle while o_stall is low. A test word passes through the
// input register, gap stage, square stage and result register before its result shows.
// Load words update the stored collider as they leave the input register and
// give no result. Reset clears all stage valids and the stored-collider flag.
// A stalled result holds; stall ripples back only through full stages.
module box_sphere_overlap_test (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_opcode,
    input  logic signed [bsot_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [bsot_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [bsot_pkg::POS_W-1:0]  i_pos_z,
    input  logic        [bsot_pkg::SIZE_W-1:0] i_size_x,
    input  logic        [bsot_pkg::SIZE_W-1:0] i_size_y,
    input  logic        [bsot_pkg::SIZE_W-1:0] i_size_z,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_collide,
    output logic                               o_status
);

    // Input register
    logic                              r0_valid;
    bsot_pkg::t_opcode                 r0_opcode;
    logic signed [bsot_pkg::POS_W-1:0] r0_pos  [bsot_pkg::AXES];
    logic        [bsot_pkg::SIZE_W-1:0] r0_size [bsot_pkg::AXES];

    // Stored first collider
    logic                               r_first_valid;
    logic                               r_first_is_sphere;
    logic signed [bsot_pkg::POS_W-1:0]  r_first_center [bsot_pkg::AXES];
    logic        [bsot_pkg::SIZE_W-1:0] r_first_extent [bsot_pkg::AXES];

    // Gap stage
    bsot_pkg::t_ctl                    r1_ctl;
    bsot_pkg::t_ctl                    n1_ctl;
    logic [bsot_pkg::MAG_W-1:0]        r1_dist [bsot_pkg::AXES];
    logic [bsot_pkg::MAG_W-1:0]        r1_rad;
    logic [bsot_pkg::MAG_W-1:0]        n1_rad;

    // Square stage
    bsot_pkg::t_ctl                    r2_ctl;
    logic [bsot_pkg::SQ_W-1:0]         sq_dist [bsot_pkg::AXES];
    logic [bsot_pkg::SQ_W-1:0]         sq_rad;

    // Result register
    logic                              r3_valid;
    logic                              r3_collide;
    logic                              r3_status;
    logic                              n3_collide;

    logic en0, en1, en2, en3;
    logic is_load;
    logic test_sphere;
    logic [bsot_pkg::AXES-1:0] overlap;
    logic [bsot_pkg::MAG_W-1:0] gap [bsot_pkg::AXES];
    logic [bsot_pkg::SIZE_W:0]  rad_sum;
    logic [bsot_pkg::SUM_W-1:0] dist_sum;

    // Advance each stage when it is empty or the one after it moves
    assign en3 = !r3_valid || !i_stall;
    assign en2 = !r2_ctl.valid || en3;
    assign en1 = !r1_ctl.valid || en2;
    assign en0 = !r0_valid || en1;
    assign o_stall = !en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (en0) begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0 && i_valid) begin
            r0_opcode  <= bsot_pkg::t_opcode'(i_opcode);
            r0_pos[0]  <= i_pos_x;
            r0_pos[1]  <= i_pos_y;
            r0_pos[2]  <= i_pos_z;
            r0_size[0] <= i_size_x;
            r0_size[1] <= i_size_y;
            r0_size[2] <= i_size_z;
        end
    end

    assign is_load = (r0_opcode == bsot_pkg::OP_LOAD_BOX) ||
                     (r0_opcode == bsot_pkg::OP_LOAD_SPHERE);
    assign test_sphere = (r0_opcode == bsot_pkg::OP_TEST_SPHERE);

    // Store the collider as a load word leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_valid     <= 1'b0;
            r_first_is_sphere <= 1'b0;
        end else if (r0_valid && en1 && is_load) begin
            r_first_valid     <= 1'b1;
            r_first_is_sphere <= (r0_opcode == bsot_pkg::OP_LOAD_SPHERE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r0_valid && en1 && is_load) begin
            r_first_center <= r0_pos;
            r_first_extent <= r0_size;
        end
    end

    // Box side is the stored box, or the tested box against a stored sphere;
    // sphere against sphere uses a zero-size box at the tested centre.
    for (genvar g = 0; g < bsot_pkg::AXES; g++) begin : g_axis
        logic signed [bsot_pkg::POS_W-1:0]  box_c;
        logic        [bsot_pkg::SIZE_W-1:0] box_s;
        logic signed [bsot_pkg::POS_W-1:0]  oth_c;

        assign box_c = r_first_is_sphere ? r0_pos[g] : r_first_center[g];
        assign box_s = r_first_is_sphere ? (test_sphere ? '0 : r0_size[g])
                                         : r_first_extent[g];
        assign oth_c = r_first_is_sphere ? r_first_center[g] : r0_pos[g];

        bsot_axis u_axis (
            .i_box_c   (box_c),
            .i_box_s   (box_s),
            .i_oth_c   (oth_c),
            .i_oth_s   (r0_size[g]),
            .o_overlap (overlap[g]),
            .o_dist    (gap[g])
        );
    end

    assign rad_sum = (r_first_is_sphere ? (bsot_pkg::SIZE_W+1)'(r_first_extent[0]) : '0) +
                     (test_sphere ? (bsot_pkg::SIZE_W+1)'(r0_size[0]) : '0);
    assign n1_rad  = bsot_pkg::MAG_W'(rad_sum) << 1;

    always_comb begin
        n1_ctl.valid   = r0_valid && !is_load;
        n1_ctl.box_hit = &overlap;
        if (!r_first_valid) begin
            n1_ctl.mode = bsot_pkg::MODE_NO_FIRST;
        end else if (!test_sphere && !r_first_is_sphere) begin
            n1_ctl.mode = bsot_pkg::MODE_BOX_BOX;
        end else begin
            n1_ctl.mode = bsot_pkg::MODE_SQUARED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl.valid <= 1'b0;
        end else if (en1) begin
            r1_ctl.valid <= n1_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_ctl.mode    <= n1_ctl.mode;
            r1_ctl.box_hit <= n1_ctl.box_hit;
            r1_dist        <= gap;
            r1_rad         <= n1_rad;
        end
    end

    for (genvar g = 0; g < bsot_pkg::AXES; g++) begin : g_sq
        bsot_sq u_sq (
            .i_clk (i_clk),
            .i_en  (en2),
            .i_val (r1_dist[g]),
            .o_sq  (sq_dist[g])
        );
    end

    bsot_sq u_sq_rad (
        .i_clk (i_clk),
        .i_en  (en2),
        .i_val (r1_rad),
        .o_sq  (sq_rad)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl.valid <= 1'b0;
        end else if (en2) begin
            r2_ctl.valid <= r1_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_ctl.mode    <= r1_ctl.mode;
            r2_ctl.box_hit <= r1_ctl.box_hit;
        end
    end

    assign dist_sum = bsot_pkg::SUM_W'(sq_dist[0]) + bsot_pkg::SUM_W'(sq_dist[1]) +
                      bsot_pkg::SUM_W'(sq_dist[2]);

    always_comb begin
        case (r2_ctl.mode)
            bsot_pkg::MODE_BOX_BOX: n3_collide = r2_ctl.box_hit;
            bsot_pkg::MODE_SQUARED: n3_collide = dist_sum < bsot_pkg::SUM_W'(sq_rad);
            default:                n3_collide = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en3) begin
            r3_valid <= r2_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_collide <= n3_collide;
            r3_status  <= (r2_ctl.mode == bsot_pkg::MODE_NO_FIRST);
        end
    end

    assign o_valid   = r3_valid;
    assign o_collide = r3_collide;
    assign o_status  = r3_status;

endmodule
